/* src/merge_two_sorted_runs_macros.svh */
// Assertion macros shared by the merge_two_sorted_runs RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef MERGE_TWO_SORTED_RUNS_MACROS_SVH
`define MERGE_TWO_SORTED_RUNS_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MTSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define MTSR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/mtsr_pkg.sv */
// Package for merge_two_sorted_runs: widths, register indexes, status codes
// and the job descriptor passed from the load front end to the merge engine.
// No dependencies.
package mtsr_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int STATUS_W      = 2;
  localparam int DEF_ARRAY_DEPTH = 64;
  localparam int JOB_Q_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_END   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RUNS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] run_start;
    logic [IDX_W-1:0] run_mid;
    logic [IDX_W-1:0] run_end;
  } bounds_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             overflow;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

/* src/mtsr_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module mtsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/mtsr_front.sv */
// Load front end: stores each accepted word at the next index while there
// is room, tracks overflow and posts a job descriptor on the last word. Uses mtsr_pkg.
module mtsr_front import mtsr_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic signed [DATA_W-1:0]       in_value,
  input  logic                           in_last,
  output logic                           ram_we,
  output logic [$clog2(ARRAY_DEPTH)-1:0] ram_waddr,
  output logic [DATA_W-1:0]              ram_wdata,
  output logic                           push,
  output job_t                           push_job
);

  localparam int AW = $clog2(ARRAY_DEPTH);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             room;

  assign room      = count_r < CNT_W'(ARRAY_DEPTH);
  assign ram_we    = accept && room;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_value;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    push              = accept && in_last;
    push_job.count    = count_nxt;
    push_job.overflow = ovf_nxt;
    // The descriptor carries the totals, so the counters start over.
    if (push) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* src/mtsr_job_q.sv */
// Short FIFO of job descriptors between the load front end and the merge
// engine. Uses mtsr_pkg and the assertion macros.
`include "merge_two_sorted_runs_macros.svh"
module mtsr_job_q import mtsr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  localparam int PW = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int CW = $clog2(JOB_Q_DEPTH + 1);

  job_t          slots_r [JOB_Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(JOB_Q_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign stat.not_empty = fill_r != '0;
  assign stat.full      = fill_r == CW'(JOB_Q_DEPTH);
  assign head           = slots_r[rd_ptr_r];
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? bump(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // A request that finds the queue full would lose a whole array.
  `MTSR_ASSERT_NEVER(a_q_push_when_full, push && stat.full, "job pushed into full queue")

endmodule

/* src/mtsr_back.sv */
// Merge engine: takes a job, checks the run bounds, then walks the array in
// index order, merging the two runs from two RAM read ports. Uses mtsr_pkg.
`include "merge_two_sorted_runs_macros.svh"
module mtsr_back import mtsr_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bounds_t                        bounds,
  input  job_t                           job,
  input  q_stat_t                        q_stat,
  output logic                           pop,
  output logic                           active,
  output logic [$clog2(ARRAY_DEPTH)-1:0] raddr_a,
  input  logic [DATA_W-1:0]              rdata_a,
  output logic [$clog2(ARRAY_DEPTH)-1:0] raddr_b,
  input  logic [DATA_W-1:0]              rdata_b,
  output logic                           out_valid,
  output logic signed [DATA_W-1:0]       out_value,
  output logic [IDX_W-1:0]               out_index,
  output logic                           out_last,
  output logic [STATUS_W-1:0]            out_status
);

  localparam int AW = $clog2(ARRAY_DEPTH);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_ISSUE = 2'd1;
  localparam logic [1:0] B_EMIT  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic [CNT_W-1:0]    mid_r, mid_nxt, end_r, end_nxt, start_r, start_nxt;
  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic [IDX_W-1:0]    out_index_r, out_index_nxt;
  logic                out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [CNT_W-1:0]    b_start, b_mid, b_end;
  logic                bounds_ok, in_seg, take_a;

  assign b_start   = CNT_W'(bounds.run_start);
  assign b_mid     = CNT_W'(bounds.run_mid);
  assign b_end     = CNT_W'(bounds.run_end);
  assign bounds_ok = (b_start <= b_mid) && (b_mid <= b_end) && (b_end < job.count);

  assign in_seg = valid_r && (k_r >= start_r) && (k_r <= end_r);
  // Ties go to the first run, which keeps the merge stable.
  assign take_a = (j_r > end_r) ||
                  ((i_r <= mid_r) && ($signed(rdata_a) <= $signed(rdata_b)));

  // Outside the merged segment port A reads the element in place.
  assign raddr_a = in_seg ? i_r[AW-1:0] : k_r[AW-1:0];
  assign raddr_b = j_r[AW-1:0];

  assign pop    = (state_r == B_IDLE) && q_stat.not_empty;
  assign active = state_r != B_IDLE;

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    start_nxt      = start_r;
    mid_nxt        = mid_r;
    end_nxt        = end_r;
    valid_nxt      = valid_r;
    status_nxt     = status_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_stat.not_empty) begin
          start_nxt = b_start;
          mid_nxt   = b_mid;
          end_nxt   = b_end;
          valid_nxt = bounds_ok;
          n_nxt     = job.count;
          i_nxt     = b_start;
          j_nxt     = b_mid + CNT_W'(1);
          k_nxt     = '0;
          priority if (job.overflow) begin
            status_nxt = STATUS_OVERFLOW;
          end else if (!bounds_ok) begin
            status_nxt = STATUS_BAD_RUNS;
          end else begin
            status_nxt = STATUS_OK;
          end
          state_nxt = B_ISSUE;
        end
      end
      B_ISSUE: begin
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_index_nxt  = k_r[IDX_W-1:0];
        out_last_nxt   = (k_r + CNT_W'(1)) == n_r;
        out_status_nxt = status_r;
        if (in_seg && !take_a) begin
          out_value_nxt = rdata_b;
          j_nxt         = j_r + CNT_W'(1);
        end else begin
          out_value_nxt = rdata_a;
          if (in_seg) begin
            i_nxt = i_r + CNT_W'(1);
          end
        end
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = ((k_r + CNT_W'(1)) == n_r) ? B_IDLE : B_ISSUE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    start_r      <= start_nxt;
    mid_r        <= mid_nxt;
    end_r        <= end_nxt;
    valid_r      <= valid_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  `MTSR_ASSERT(a_issue_then_emit, (state_r == B_ISSUE) |=> (state_r == B_EMIT), "issue not followed by emit")
  `MTSR_ASSERT(a_index_below_count, (state_r != B_IDLE) |-> (k_r < n_r), "emit index past array end")
  `MTSR_ASSERT(a_heads_bounded, (state_r != B_IDLE && valid_r) |-> (i_r <= mid_r + CNT_W'(1) && j_r <= end_r + CNT_W'(1)), "run head ran past its run")
  `MTSR_ASSERT(a_gap_after_last, (out_valid_r && out_last_r) |=> !out_valid_r, "result right after final element")

endmodule

/* src/merge_two_sorted_runs.sv */
// Merge step: loads one word per cycle (start high, busy low).
// Accepting the last word queues a job; the merge engine pops it, then each
// result comes from its RAM read (ISSUE) and select (EMIT) states in turn;
// busy stays high until the final element is selected. Results cannot be stalled.
// Synchronous active-low reset clears counters, queue and run bounds; the
// array RAM is not cleared.
module merge_two_sorted_runs import mtsr_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [DATA_W-1:0]   in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_value,
  output logic [IDX_W-1:0]           out_index,
  output logic                       out_last,
  output logic [STATUS_W-1:0]        out_status,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [IDX_W-1:0]           cfg_wdata
);

  localparam int AW = $clog2(ARRAY_DEPTH);

  bounds_t           bounds_r, bounds_nxt;
  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] ram_wdata, rdata_a, rdata_b;
  logic              push, pop, back_active;
  job_t              push_job, head_job;
  q_stat_t           q_stat;

  // A new array may load only once the previous one is fully handed off.
  assign busy   = q_stat.not_empty || back_active;
  assign accept = start && !busy;

  always_comb begin
    bounds_nxt = bounds_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_START: bounds_nxt.run_start = cfg_wdata;
        REG_RUN_MID:   bounds_nxt.run_mid   = cfg_wdata;
        REG_RUN_END:   bounds_nxt.run_end   = cfg_wdata;
        default:       bounds_nxt = bounds_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r <= '0;
    end else begin
      bounds_r <= bounds_nxt;
    end
  end

  mtsr_front #(.ARRAY_DEPTH(ARRAY_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_value  (in_value),
    .in_last   (in_last),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_job  (push_job)
  );

  mtsr_ram #(.WIDTH(DATA_W), .DEPTH(ARRAY_DEPTH)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  mtsr_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .stat     (q_stat)
  );

  mtsr_back #(.ARRAY_DEPTH(ARRAY_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bounds     (bounds_r),
    .job        (head_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .active     (back_active),
    .raddr_a    (raddr_a),
    .rdata_a    (rdata_a),
    .raddr_b    (raddr_b),
    .rdata_b    (rdata_b),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_index  (out_index),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for merge_two_sorted_runs: directed table, then random arrays of sorted runs.
// Every emitted element is checked against a predictor kept in this file.
// Needs mtsr_pkg and the merge_two_sorted_runs RTL.
module tb import mtsr_pkg::*;;

  localparam int ARRAY_DEPTH  = DEF_ARRAY_DEPTH;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0]     data;
    logic                  last;
    logic                  typed;
    logic [STATUS_W-1:0]   exp_status;
  } row_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     last;
    logic [STATUS_W-1:0]      status;
  } elem_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]         out_index;
  logic                     out_last;
  logic [STATUS_W-1:0]      out_status;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [IDX_W-1:0]         cfg_wdata = '0;

  merge_two_sorted_runs #(.ARRAY_DEPTH(ARRAY_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_index (out_index),
    .out_last  (out_last),
    .out_status(out_status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: the array being loaded and the run bounds.
  logic signed [DATA_W-1:0] stored_vals [ARRAY_DEPTH];
  int    load_n = 0;
  bit    dropped = 1'b0;
  int    run_lo = 0;
  int    run_md = 0;
  int    run_hi = 0;

  elem_t expected_elems [$];
  bit    typed_armed = 1'b0;
  elem_t typed_elem;

  int    error_count = 0;
  int    items_sent = 0;
  int    burst_left = 0;
  int    cycle_count = 0;
  row_t  plan [$];

  function automatic void take_item(logic signed [DATA_W-1:0] v, logic l);
    logic signed [DATA_W-1:0] merged [ARRAY_DEPTH];
    logic [STATUS_W-1:0] st;
    bit ok;
    int i, j, k;
    if (load_n < ARRAY_DEPTH) begin
      stored_vals[load_n] = v;
      load_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!l) return;
    for (k = 0; k < load_n; k++) merged[k] = stored_vals[k];
    ok = (run_lo <= run_md) && (run_md <= run_hi) && (run_hi < load_n);
    if (ok) begin
      i = run_lo;
      j = run_md + 1;
      // Stable merge: on equal values the first run goes first.
      for (k = run_lo; k <= run_hi; k++) begin
        if (j > run_hi || (i <= run_md && stored_vals[i] <= stored_vals[j])) begin
          merged[k] = stored_vals[i];
          i++;
        end else begin
          merged[k] = stored_vals[j];
          j++;
        end
      end
    end
    if (dropped) st = STATUS_OVERFLOW;
    else if (!ok) st = STATUS_BAD_RUNS;
    else st = STATUS_OK;
    if (typed_armed) begin
      expected_elems.push_back(typed_elem);
      typed_armed = 1'b0;
    end else begin
      for (k = 0; k < load_n; k++)
        expected_elems.push_back('{merged[k], IDX_W'(k), k == load_n - 1, st});
    end
    load_n = 0;
    dropped = 1'b0;
  endfunction

  function automatic void check_elem();
    elem_t e;
    if (expected_elems.size() == 0) begin
      $error("unexpected result: out_index %0d, out_value %0d", out_index, out_value);
      error_count++;
      return;
    end
    e = expected_elems.pop_front();
    if (out_value !== e.value) begin
      $error("out_value: expected %0d, got %0d", e.value, out_value);
      error_count++;
    end
    if (out_index !== e.index) begin
      $error("out_index: expected %0d, got %0d", e.index, out_index);
      error_count++;
    end
    if (out_last !== e.last) begin
      $error("out_last: expected %0d, got %0d", e.last, out_last);
      error_count++;
    end
    if (out_status !== e.status) begin
      $error("out_status: expected %0d, got %0d", e.status, out_status);
      error_count++;
    end
  endfunction

  // Busy and start are sampled before the edge updates them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) take_item(in_value, in_last);
      if (out_valid) check_elem();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** merge_two_sorted_runs: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic l);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_elems.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RUN_START: run_lo = int'(d);
      REG_RUN_MID:   run_md = int'(d);
      REG_RUN_END:   run_hi = int'(d);
      default: ;
    endcase
  endtask

  // Sends one array of n items; inside the segment both runs ascend unless noisy.
  task automatic send_array(input int n, input bit noisy);
    longint run_v;
    bit tight;
    int k;
    logic signed [DATA_W-1:0] v;
    tight = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n; k++) begin
      if (noisy || k < run_lo || k > run_hi) begin
        v = $urandom;
      end else if (k == run_lo || k == run_md + 1) begin
        run_v = tight ? longint'($urandom_range(0, 8)) - 4 : longint'($signed($urandom));
        v = run_v[DATA_W-1:0];
      end else begin
        run_v += tight ? longint'($urandom_range(0, 2))
                       : (longint'($urandom) >> $urandom_range(0, 31));
        if (run_v > 64'sd2147483647) run_v = 64'sd2147483647;
        v = run_v[DATA_W-1:0];
      end
      send_item(v, k == n - 1);
    end
  endtask

  task automatic pick_bounds();
    int s, m, e;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        s = $urandom_range(0, 6);
        m = s + $urandom_range(0, 5);
        e = m + $urandom_range(0, 6);
      end
      6: begin
        s = $urandom_range(0, 20);
        m = $urandom_range(s, 40);
        e = $urandom_range(m, 63);
      end
      7: begin
        s = $urandom_range(1, 10);
        m = $urandom_range(0, s - 1);
        e = $urandom_range(0, 20);
      end
      8: begin
        m = $urandom_range(1, 12);
        e = $urandom_range(0, m - 1);
        s = $urandom_range(0, m);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: begin s = 0;  m = 0;  e = 0;  end
          1: begin s = 63; m = 63; e = 63; end
          2: begin s = 0;  m = 31; e = 63; end
          3: begin s = 0;  m = 62; e = 63; end
          default: begin s = 0; m = 0; e = 63; end
        endcase
      end
    endcase
    cfg_write(REG_RUN_START, IDX_W'(s));
    cfg_write(REG_RUN_MID, IDX_W'(m));
    cfg_write(REG_RUN_END, IDX_W'(e));
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, IDX_W'($urandom));
  endtask

  function automatic row_t item_row(logic [DATA_W-1:0] d, logic l);
    return '{ROW_ITEM, REG_UNUSED, d, l, 1'b0, STATUS_OK};
  endfunction

  function automatic row_t typed_row(logic [DATA_W-1:0] d, logic [STATUS_W-1:0] st);
    return '{ROW_ITEM, REG_UNUSED, d, 1'b1, 1'b1, st};
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int d);
    return '{ROW_CFG, idx, DATA_W'(d), 1'b0, 1'b0, STATUS_OK};
  endfunction

  function automatic row_t fill_row(int n);
    return '{ROW_FILL, REG_UNUSED, DATA_W'(n), 1'b0, 1'b0, STATUS_OK};
  endfunction

  initial begin
    int goal, n, arrays;
    row_t r;
    plan = '{
      // Single-element arrays at the reset bounds hold the extreme values.
      typed_row(32'h8000_0000, STATUS_OK),
      typed_row(32'h7FFF_FFFF, STATUS_OK),
      cfg_row(REG_RUN_START, 0), cfg_row(REG_RUN_MID, 1), cfg_row(REG_RUN_END, 3),
      // Tie between the runs, then extremes in both runs.
      item_row(32'd5, 1'b0), item_row(32'd7, 1'b0),
      item_row(32'hFFFF_FFFD, 1'b0), item_row(32'd7, 1'b1),
      item_row(32'h8000_0000, 1'b0), item_row(32'h7FFF_FFFF, 1'b0),
      item_row(32'h8000_0000, 1'b0), item_row(32'h7FFF_FFFF, 1'b1),
      // Second run ends past the loaded count.
      cfg_row(REG_RUN_END, 5),
      typed_row(32'd42, STATUS_BAD_RUNS),
      // First run starts after it ends.
      cfg_row(REG_RUN_START, 2), cfg_row(REG_RUN_END, 3),
      item_row(32'd4, 1'b0), item_row(32'd3, 1'b0),
      item_row(32'd2, 1'b0), item_row(32'd1, 1'b1),
      // Middle beyond the end of the second run.
      cfg_row(REG_RUN_START, 0), cfg_row(REG_RUN_MID, 3), cfg_row(REG_RUN_END, 2),
      item_row(32'd9, 1'b0), item_row(32'd8, 1'b0), item_row(32'd7, 1'b1),
      // Empty second run is valid and leaves the array as it is.
      cfg_row(REG_RUN_START, 1), cfg_row(REG_RUN_MID, 2), cfg_row(REG_RUN_END, 2),
      item_row(32'd3, 1'b0), item_row(32'd1, 1'b0), item_row(32'd2, 1'b1),
      // A write to the unused index must not move the bounds.
      cfg_row(REG_UNUSED, 63),
      typed_row(32'd11, STATUS_BAD_RUNS),
      // Full store, then overflow with the last item dropped, then overflow over bad bounds.
      cfg_row(REG_RUN_START, 0), cfg_row(REG_RUN_MID, 31), cfg_row(REG_RUN_END, 63),
      fill_row(ARRAY_DEPTH), fill_row(ARRAY_DEPTH + 1),
      cfg_row(REG_RUN_START, 40),
      fill_row(ARRAY_DEPTH + 2)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      case (r.kind)
        ROW_CFG: begin
          wait_idle();
          cfg_write(r.reg_idx, r.data[IDX_W-1:0]);
        end
        ROW_FILL: send_array(int'(r.data), 1'b0);
        default: begin
          if (r.typed) begin
            typed_elem  = '{$signed(r.data), '0, 1'b1, r.exp_status};
            typed_armed = 1'b1;
          end
          send_item($signed(r.data), r.last);
        end
      endcase
    end

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      // The sender holds off here until every pending result has come.
      wait_idle();
      pick_bounds();
      arrays = $urandom_range(1, 4);
      repeat (arrays) begin
        if ($urandom_range(0, 15) == 0) begin
          n = ARRAY_DEPTH + $urandom_range(1, 3);
        end else if (run_lo <= run_md && run_md <= run_hi && run_hi > 0 &&
                     $urandom_range(0, 7) == 0) begin
          n = $urandom_range(1, run_hi);
        end else begin
          n = run_hi + 1 + $urandom_range(0, 4);
          if (n > ARRAY_DEPTH) n = ARRAY_DEPTH;
        end
        send_array(n, $urandom_range(0, 7) == 0);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("** merge_two_sorted_runs: PASSED **");
    end else begin
      $display("** merge_two_sorted_runs: FAILED **");
    end
    $finish;
  end

endmodule
